### rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Widths, constants and shared types of the swept circle versus arc
// contact time pipeline.
// ----------------------------------------------------------------------------
package sca_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int TIME_FRAC_BITS  = 16;

	localparam int CW    = 20;  // input coordinate width
	localparam int RW    = 16;  // radius width
	localparam int DW    = 21;  // offset between centers
	localparam int DSQ_W = 42;  // squared distance
	localparam int VSQ_W = 40;  // squared move
	localparam int DOT_W = 42;  // offset dot move, signed
	localparam int DAB_W = 41;  // magnitude of the dot product
	localparam int C_W   = 43;  // constant term of the quadratic, signed
	localparam int Q_W   = 84;  // quadratic value scaled by 2^32, signed
	localparam int A_W   = 58;  // squared move times the time found so far
	localparam int LIM_W = 58;  // vertex limit of the outer search
	localparam int T_W   = 18;  // time, Q2.16
	localparam int PX_W  = 40;  // contact offset scaled by 2^16, signed

	localparam int SRCH_BITS  = 18;
	localparam int SRCH_IDX_W = 5;

	localparam logic [T_W-1:0] TIME_ONE  = T_W'(1) << TIME_FRAC_BITS;
	localparam logic [T_W-1:0] TIME_ZERO = '0;

	// |v|^2 * 10000 > 2^(2F) holds exactly when |v|^2 exceeds this floor.
	localparam longint MOVE_MIN = (longint'(1) << (2 * COORD_FRAC_BITS)) / 10000;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_OUTER,
		MODE_INNER
	} mode_t;

	typedef struct packed {
		logic signed [CW-1:0] circle_x;
		logic signed [CW-1:0] circle_y;
		logic signed [CW-1:0] move_x;
		logic signed [CW-1:0] move_y;
		logic signed [CW-1:0] arc_x;
		logic signed [CW-1:0] arc_y;
		logic                 quadrant_x_negative;
		logic                 quadrant_y_negative;
		logic [RW-1:0]        arc_radius;
		logic [RW-1:0]        circle_radius;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic                 xneg;
		logic                 yneg;
	} geo_t;

	typedef struct packed {
		geo_t                    geo;
		mode_t                   mode;
		logic [T_W-1:0]          tfix;
		logic [T_W-1:0]          k;
		logic signed [Q_W-1:0]   q;
		logic [A_W-1:0]          acc;
		logic [VSQ_W-1:0]        vsq;
		logic signed [DOT_W-1:0] dot;
		logic [LIM_W-1:0]        lim;
	} srch_t;

endpackage

### rtl/sca_in_if.sv
// ----------------------------------------------------------------------------
// sca_in_if
// Query channel: one circle and one arc per word.
// ----------------------------------------------------------------------------
interface sca_in_if;
	import sca_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] circle_x;
	logic signed [CW-1:0] circle_y;
	logic signed [CW-1:0] move_x;
	logic signed [CW-1:0] move_y;
	logic signed [CW-1:0] arc_x;
	logic signed [CW-1:0] arc_y;
	logic                 quadrant_x_negative;
	logic                 quadrant_y_negative;
	logic [RW-1:0]        arc_radius;
	logic [RW-1:0]        circle_radius;

	modport source(output valid, circle_x, circle_y, move_x, move_y, arc_x, arc_y,
		quadrant_x_negative, quadrant_y_negative, arc_radius, circle_radius,
		input ready);
	modport sink(input valid, circle_x, circle_y, move_x, move_y, arc_x, arc_y,
		quadrant_x_negative, quadrant_y_negative, arc_radius, circle_radius,
		output ready);
endinterface

### rtl/sca_out_if.sv
// ----------------------------------------------------------------------------
// sca_out_if
// Result channel: one contact time per word.
// ----------------------------------------------------------------------------
interface sca_out_if;
	import sca_pkg::*;

	logic           valid;
	logic           ready;
	logic [T_W-1:0] contact_time;

	modport source(output valid, contact_time, input ready);
	modport sink(input valid, contact_time, output ready);
endinterface

### rtl/sca_prep.sv
// ----------------------------------------------------------------------------
// sca_prep
// Seven stages that form the quadratic's coefficients, classify the circle
// against the ring and test the discriminant, then seed the time search.
// ----------------------------------------------------------------------------
module sca_prep (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sca_pkg::req_t  in_word,
	output logic           out_valid,
	output sca_pkg::srch_t out_word
);
	import sca_pkg::*;

	typedef struct packed {
		geo_t                    geo;
		logic                    outer;
		logic                    inner;
		logic                    moving;
		logic signed [C_W-1:0]   c;
		logic [DAB_W-1:0]        dabs;
		logic [VSQ_W-1:0]        vsq;
		logic signed [DOT_W-1:0] dot;
	} cls_t;

	logic [6:0] v_q;

	// Stage 1
	geo_t               geo_s1;
	logic [RW:0]        r1_s1;
	logic [RW-1:0]      r2_s1;
	// Stage 2
	geo_t               geo_s2;
	logic [DSQ_W-1:0]   dxx_s2, dyy_s2;
	logic [VSQ_W-1:0]   vxx_s2, vyy_s2;
	logic signed [DW+CW-1:0] dxv_s2, dyv_s2;
	logic [2*RW+1:0]    r1sq_s2;
	logic [2*RW-1:0]    r2sq_s2;
	// Stage 3
	geo_t               geo_s3;
	logic [DSQ_W-1:0]   dist_s3;
	logic [VSQ_W-1:0]   vsq_s3;
	logic signed [DOT_W-1:0] dot_s3;
	logic [2*RW+1:0]    r1sq_s3;
	logic [2*RW-1:0]    r2sq_s3;
	// Stages 4 to 6
	cls_t               cls_s4, cls_s5, cls_s6;
	logic [2*DW-1:0]    dll_s5;
	logic [2*DW-2:0]    dlh_s5;
	logic [2*DW-3:0]    dhh_s5;
	logic [2*DW-2:0]    vlcl_s5, vlch_s5, vhcl_s5, vhch_s5;
	logic [Q_W-1:0]     dd_s6, vc_s6;
	// Stage 7
	srch_t              word_s7;

	logic signed [2*DW-1:0]  dxx_m, dyy_m;
	logic signed [2*CW-1:0]  vxx_m, vyy_m;
	logic [DSQ_W:0]          c_full;
	logic [DOT_W-1:0]        dot_neg;
	logic                    outer_c;
	logic                    rad_ok;
	mode_t                   mode_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	assign dxx_m = geo_s1.dx * geo_s1.dx;
	assign dyy_m = geo_s1.dy * geo_s1.dy;
	assign vxx_m = geo_s1.vx * geo_s1.vx;
	assign vyy_m = geo_s1.vy * geo_s1.vy;

	assign outer_c = dist_s3 > DSQ_W'(r1sq_s3);
	assign c_full  = {1'b0, dist_s3} - (outer_c ? (DSQ_W+1)'(r1sq_s3) : (DSQ_W+1)'(r2sq_s3));
	assign dot_neg = -dot_s3;

	assign rad_ok = dd_s6 >= vc_s6;

	always_comb begin
		if (cls_s6.outer && cls_s6.moving && cls_s6.dot[DOT_W-1] && rad_ok) begin
			mode_c = MODE_OUTER;
		end else if (cls_s6.inner && cls_s6.moving) begin
			mode_c = MODE_INNER;
		end else begin
			mode_c = MODE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: offsets and the two ring radii.
			geo_s1.dx   <= DW'(in_word.circle_x) - DW'(in_word.arc_x);
			geo_s1.dy   <= DW'(in_word.circle_y) - DW'(in_word.arc_y);
			geo_s1.vx   <= in_word.move_x;
			geo_s1.vy   <= in_word.move_y;
			geo_s1.xneg <= in_word.quadrant_x_negative;
			geo_s1.yneg <= in_word.quadrant_y_negative;
			r1_s1 <= {1'b0, in_word.arc_radius} + {1'b0, in_word.circle_radius};
			r2_s1 <= (in_word.arc_radius >= in_word.circle_radius) ?
				in_word.arc_radius - in_word.circle_radius :
				in_word.circle_radius - in_word.arc_radius;

			// Stage 2: products.
			geo_s2  <= geo_s1;
			dxx_s2  <= DSQ_W'(dxx_m);
			dyy_s2  <= DSQ_W'(dyy_m);
			vxx_s2  <= VSQ_W'(vxx_m);
			vyy_s2  <= VSQ_W'(vyy_m);
			dxv_s2  <= geo_s1.dx * geo_s1.vx;
			dyv_s2  <= geo_s1.dy * geo_s1.vy;
			r1sq_s2 <= r1_s1 * r1_s1;
			r2sq_s2 <= r2_s1 * r2_s1;

			// Stage 3: sums.
			geo_s3  <= geo_s2;
			dist_s3 <= dxx_s2 + dyy_s2;
			vsq_s3  <= vxx_s2 + vyy_s2;
			dot_s3  <= DOT_W'(dxv_s2) + DOT_W'(dyv_s2);
			r1sq_s3 <= r1sq_s2;
			r2sq_s3 <= r2sq_s2;

			// Stage 4: classify against the ring.
			cls_s4.geo    <= geo_s3;
			cls_s4.outer  <= outer_c;
			cls_s4.inner  <= !outer_c && (dist_s3 < DSQ_W'(r2sq_s3));
			cls_s4.moving <= vsq_s3 > VSQ_W'(MOVE_MIN);
			cls_s4.c      <= C_W'(c_full);
			cls_s4.dabs   <= dot_s3[DOT_W-1] ? dot_neg[DAB_W-1:0] : dot_s3[DAB_W-1:0];
			cls_s4.vsq    <= vsq_s3;
			cls_s4.dot    <= dot_s3;

			// Stage 5: partial products of dot^2 and |v|^2 * c.
			cls_s5  <= cls_s4;
			dll_s5  <= cls_s4.dabs[20:0] * cls_s4.dabs[20:0];
			dlh_s5  <= cls_s4.dabs[20:0] * cls_s4.dabs[40:21];
			dhh_s5  <= cls_s4.dabs[40:21] * cls_s4.dabs[40:21];
			vlcl_s5 <= cls_s4.vsq[19:0] * cls_s4.c[20:0];
			vlch_s5 <= cls_s4.vsq[19:0] * cls_s4.c[41:21];
			vhcl_s5 <= cls_s4.vsq[39:20] * cls_s4.c[20:0];
			vhch_s5 <= cls_s4.vsq[39:20] * cls_s4.c[41:21];

			// Stage 6: assemble the two sides of the discriminant.
			cls_s6 <= cls_s5;
			dd_s6  <= (Q_W'(dhh_s5) << 42) + (Q_W'(dlh_s5) << 22) + Q_W'(dll_s5);
			vc_s6  <= (Q_W'(vhch_s5) << 41) + (Q_W'(vhcl_s5) << 20) +
				(Q_W'(vlch_s5) << 21) + Q_W'(vlcl_s5);

			// Stage 7: seed the search at time zero.
			word_s7.geo  <= cls_s6.geo;
			word_s7.mode <= mode_c;
			word_s7.tfix <= (!cls_s6.outer && !cls_s6.inner) ? TIME_ZERO : TIME_ONE;
			word_s7.k    <= '0;
			word_s7.q    <= Q_W'(cls_s6.c) <<< 32;
			word_s7.acc  <= '0;
			word_s7.vsq  <= cls_s6.vsq;
			word_s7.dot  <= cls_s6.dot;
			word_s7.lim  <= LIM_W'({cls_s6.dabs, 16'b0});
		end
	end

	assign out_valid = v_q[6];
	assign out_word  = word_s7;
endmodule

### rtl/sca_search_stage.sv
// ----------------------------------------------------------------------------
// sca_search_stage
// One bit of the time search. The quadratic at the candidate time is
// updated from its value at the time found so far with shifts and adds.
// ----------------------------------------------------------------------------
module sca_search_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [sca_pkg::SRCH_IDX_W-1:0] bit_idx,
	input  logic                           in_valid,
	input  sca_pkg::srch_t                 in_word,
	output logic                           out_valid,
	output sca_pkg::srch_t                 out_word
);
	import sca_pkg::*;

	logic                   valid_s1;
	srch_t                  word_s1;
	logic [T_W-1:0]         cand;
	logic [5:0]             sh_acc, sh_vsq, sh_dot;
	logic [Q_W-1:0]         qc;
	logic [A_W-1:0]         ac;
	logic                   take;

	assign cand   = in_word.k | (T_W'(1) << bit_idx);
	assign sh_acc = 6'(bit_idx) + 6'd1;
	assign sh_vsq = 6'(bit_idx) << 1;
	assign sh_dot = 6'(bit_idx) + 6'(TIME_FRAC_BITS + 1);

	// Q(k + h) = Q(k) + 2h * |v|^2 k + h^2 |v|^2 + h * dot * 2^17
	assign qc = in_word.q + (Q_W'(in_word.acc) << sh_acc) +
		(Q_W'(in_word.vsq) << sh_vsq) + (Q_W'(in_word.dot) << sh_dot);
	assign ac = in_word.acc + (A_W'(in_word.vsq) << bit_idx);

	always_comb begin
		unique case (in_word.mode)
			MODE_OUTER: take = (ac <= in_word.lim) && !qc[Q_W-1];
			MODE_INNER: take = (cand <= TIME_ONE) && (qc[Q_W-1] || (qc == '0));
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= in_word;
			if (take) begin
				word_s1.k   <= cand;
				word_s1.q   <= qc;
				word_s1.acc <= ac;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;
endmodule

### rtl/sca_finish.sv
// ----------------------------------------------------------------------------
// sca_finish
// Picks the time and checks the contact point against the arc's quadrant.
// ----------------------------------------------------------------------------
module sca_finish (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  sca_pkg::srch_t        in_word,
	output logic                  out_valid,
	output logic [sca_pkg::T_W-1:0] contact_time
);
	import sca_pkg::*;

	logic                      valid_s1, valid_s2;
	logic [T_W-1:0]            t_c, t_s1, time_s2;
	logic signed [T_W:0]       t_sgn;
	logic signed [T_W+CW:0]    tvx_s1, tvy_s1;
	logic signed [DW-1:0]      dx_s1, dy_s1;
	logic                      xneg_s1, yneg_s1;
	logic signed [PX_W-1:0]    px, py;
	logic                      okx, oky;

	assign t_c   = (in_word.mode == MODE_NONE) ? in_word.tfix : in_word.k;
	assign t_sgn = {1'b0, t_c};

	assign px  = (PX_W'(dx_s1) <<< TIME_FRAC_BITS) + PX_W'(tvx_s1);
	assign py  = (PX_W'(dy_s1) <<< TIME_FRAC_BITS) + PX_W'(tvy_s1);
	assign okx = xneg_s1 ? px[PX_W-1] : (!px[PX_W-1] && (px != '0));
	assign oky = yneg_s1 ? py[PX_W-1] : (!py[PX_W-1] && (py != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_c;
			tvx_s1  <= t_sgn * in_word.geo.vx;
			tvy_s1  <= t_sgn * in_word.geo.vy;
			dx_s1   <= in_word.geo.dx;
			dy_s1   <= in_word.geo.dy;
			xneg_s1 <= in_word.geo.xneg;
			yneg_s1 <= in_word.geo.yneg;
			time_s2 <= (okx && oky) ? t_s1 : TIME_ONE;
		end
	end

	assign out_valid    = valid_s2;
	assign contact_time = time_s2;
endmodule

### rtl/swept_circle_vs_quarter_arc_time.sv
// ----------------------------------------------------------------------------
// swept_circle_vs_quarter_arc_time
// First contact time of a moving circle against a quarter-circle arc.
// ----------------------------------------------------------------------------
// The req channel takes one query word: circle center, move over the step,
// arc center, quadrant signs and both radii, all fixed point. The rsp
// channel returns one word per query, the contact time in Q2.16, where
// 65536 means no hit. Words come out in the order they went in.
//
// On the way from acceptance to a valid result, seven stages form
// the coefficients and the discriminant, eighteen stages each settle one
// bit of the time, and two stages test the contact point. One word enters
// and one leaves every cycle while the receiver keeps up.
//
// All stages advance together. When a result waits on rsp and the receiver
// holds ready low, the whole pipeline holds and req.ready drops; no word is
// lost or repeated. Reset clears every valid bit, so the pipeline starts
// empty and is ready to take a word once reset is released.
// ----------------------------------------------------------------------------
module swept_circle_vs_quarter_arc_time (
	input  logic      clk,
	input  logic      arst_n,
	sca_in_if.sink    req,
	sca_out_if.source rsp
);
	import sca_pkg::*;

	logic   en;
	req_t   req_word;
	logic   prep_valid;
	srch_t  prep_word;
	logic   chain_valid [0:SRCH_BITS];
	srch_t  chain_word  [0:SRCH_BITS];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	assign req_word.circle_x            = req.circle_x;
	assign req_word.circle_y            = req.circle_y;
	assign req_word.move_x              = req.move_x;
	assign req_word.move_y              = req.move_y;
	assign req_word.arc_x               = req.arc_x;
	assign req_word.arc_y               = req.arc_y;
	assign req_word.quadrant_x_negative = req.quadrant_x_negative;
	assign req_word.quadrant_y_negative = req.quadrant_y_negative;
	assign req_word.arc_radius          = req.arc_radius;
	assign req_word.circle_radius       = req.circle_radius;

	sca_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.in_word   (req_word),
		.out_valid (prep_valid),
		.out_word  (prep_word)
	);

	assign chain_valid[0] = prep_valid;
	assign chain_word[0]  = prep_word;

	// Most significant time bit first.
	for (genvar g = 0; g < SRCH_BITS; g++) begin : g_search
		sca_search_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.bit_idx   (SRCH_IDX_W'(SRCH_BITS - 1 - g)),
			.in_valid  (chain_valid[g]),
			.in_word   (chain_word[g]),
			.out_valid (chain_valid[g+1]),
			.out_word  (chain_word[g+1])
		);
	end

	sca_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (chain_valid[SRCH_BITS]),
		.in_word      (chain_word[SRCH_BITS]),
		.out_valid    (rsp.valid),
		.contact_time (rsp.contact_time)
	);
endmodule

### rtl/sca_checker.sv
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks of the contact time pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module sca_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic [sca_pkg::T_W-1:0] contact_time
);
	import sca_pkg::*;

	// An empty output register never blocks a new word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req not ready while the output is empty");

	// A stalled result freezes the pipeline, so no word may enter.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("word accepted while the result is stalled");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	a_time_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(contact_time))
		else $error("result changed while stalled");
endmodule

bind swept_circle_vs_quarter_arc_time sca_checker u_sca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.contact_time (rsp.contact_time)
);

### tb/sca_checker.sv
// ----------------------------------------------------------------------------
// sca_tb_checker
// Watches the query and result channels of the contact time pipeline. For
// each accepted query it computes the expected contact time and queues it.
// Each result word is compared with the oldest queued time.
// ----------------------------------------------------------------------------
module sca_tb_checker (
	input  logic clk,
	input  logic arst_n,
	sca_in_if    req,
	sca_out_if   rsp,
	output int   fails,
	output int   pending
);
	import sca_pkg::*;

	typedef logic signed [127:0] s128_t;

	logic [T_W-1:0] time_q[$];

	// Quadratic |v|^2 t^2 + 2 (d.v) t + c at t = k / 2^16, scaled by 2^32.
	function automatic s128_t quad_value(longint vsq, longint dot, longint c, longint k);
		s128_t f;
		f = s128_t'(vsq) * s128_t'(k) * s128_t'(k);
		f = f + s128_t'(2 * dot) * s128_t'(k) * s128_t'(65536);
		f = f + (s128_t'(c) <<< 32);
		return f;
	endfunction

	function automatic logic [T_W-1:0] contact_time_of(req_t q);
		longint dx, dy, vx, vy, ra, rc, dsq, vsq, dot, r1, r2, c, t, k, cand;
		longint px, py;
		s128_t disc, f;
		bit moving, okx, oky;
		dx = longint'(q.circle_x) - longint'(q.arc_x);
		dy = longint'(q.circle_y) - longint'(q.arc_y);
		vx = longint'(q.move_x);
		vy = longint'(q.move_y);
		ra = longint'(q.arc_radius);
		rc = longint'(q.circle_radius);
		dsq = dx * dx + dy * dy;
		vsq = vx * vx + vy * vy;
		dot = dx * vx + dy * vy;
		r1 = ra + rc;
		r2 = ra - rc;
		moving = (vsq * 10000) > (longint'(1) << (2 * COORD_FRAC_BITS));
		t = 65536;
		if (dsq > r1 * r1) begin
			c = dsq - r1 * r1;
			disc = s128_t'(dot) * s128_t'(dot) - s128_t'(vsq) * s128_t'(c);
			if (moving && dot < 0 && disc >= 0) begin
				k = 0;
				for (int b = 17; b >= 0; b--) begin
					cand = k | (longint'(1) << b);
					if (cand * vsq <= (-dot) * 65536 && quad_value(vsq, dot, c, cand) >= 0)
						k = cand;
				end
				t = k;
			end
		end else if (dsq < r2 * r2) begin
			c = dsq - r2 * r2;
			if (moving) begin
				k = 0;
				for (int b = 16; b >= 0; b--) begin
					cand = k | (longint'(1) << b);
					if (cand <= 65536) begin
						f = quad_value(vsq, dot, c, cand);
						if (f <= 0)
							k = cand;
					end
				end
				t = k;
			end
		end else begin
			t = 0;
		end
		px = dx * 65536 + t * vx;
		py = dy * 65536 + t * vy;
		okx = q.quadrant_x_negative ? (px < 0) : (px > 0);
		oky = q.quadrant_y_negative ? (py < 0) : (py > 0);
		return (okx && oky) ? T_W'(t) : TIME_ONE;
	endfunction

	// All channel signals change only at the rising edge, so a word seen with
	// valid and ready high at the falling edge moves at the next rising edge.
	always @(negedge clk or negedge arst_n) begin
		req_t q;
		logic [T_W-1:0] want;
		if (!arst_n) begin
			fails = 0;
		end else begin
			if (req.valid && req.ready) begin
				q.circle_x            = req.circle_x;
				q.circle_y            = req.circle_y;
				q.move_x              = req.move_x;
				q.move_y              = req.move_y;
				q.arc_x               = req.arc_x;
				q.arc_y               = req.arc_y;
				q.quadrant_x_negative = req.quadrant_x_negative;
				q.quadrant_y_negative = req.quadrant_y_negative;
				q.arc_radius          = req.arc_radius;
				q.circle_radius       = req.circle_radius;
				time_q = {time_q, contact_time_of(q)};
			end
			if (rsp.valid && rsp.ready) begin
				if (time_q.size() == 0) begin
					$display("%0t: unexpected result word, actual %0d", $time,
						rsp.contact_time);
					fails++;
				end else begin
					want = time_q.pop_front();
					if (rsp.contact_time !== want) begin
						$display("%0t: contact_time mismatch, expected %0d, actual %0d",
							$time, want, rsp.contact_time);
						fails++;
					end
				end
			end
		end
		pending = time_q.size();
	end

	initial begin
		fails = 0;
		pending = 0;
	end
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives queries into the contact time pipeline in random bursts while the
// result side stalls on its own pattern; a checker alongside the block
// predicts and compares every word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import sca_pkg::*;

	localparam int RANDOM_QUERIES = 400;
	localparam int CYCLE_LIMIT    = 200000;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycles;

	sca_in_if  req ();
	sca_out_if rsp ();

	swept_circle_vs_quarter_arc_time u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sca_tb_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL swept_circle_vs_quarter_arc_time");
			$finish;
		end
	end

	// Receiver: alternates between always ready, random stalls and a
	// periodic stall, each mode held for a random stretch.
	int stall_mode;
	int stall_left;
	int stall_phase;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(2);
			stall_left <= $urandom_range(200, 10);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(99) < 60);
			default: rsp.ready <= (stall_phase % 5) != 0;
		endcase
	end

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic req_t make_query(int cx, int cy, int mx, int my, int ax, int ay,
			bit xn, bit yn, int ra, int rc);
		req_t q;
		q.circle_x = CW'(cx);
		q.circle_y = CW'(cy);
		q.move_x = CW'(mx);
		q.move_y = CW'(my);
		q.arc_x = CW'(ax);
		q.arc_y = CW'(ay);
		q.quadrant_x_negative = xn;
		q.quadrant_y_negative = yn;
		q.arc_radius = RW'(ra);
		q.circle_radius = RW'(rc);
		return q;
	endfunction

	// Random query built around an arc so that all three regions and real
	// contacts come up often; a share is fully random noise.
	function automatic req_t random_query();
		int ra, rc, span, ax, ay, ox, oy, mx, my, sel;
		req_t q;
		sel = $urandom_range(99);
		if (sel < 12) begin
			q = req_t'({$urandom, $urandom, $urandom, $urandom});
			return q;
		end
		ra = (sel < 20) ? pick(0, 65535) : pick(16, 4096);
		rc = (sel < 25) ? pick(0, 65535) : pick(0, ra);
		span = 3 * (ra + rc) + 16;
		ax = pick(-200000, 200000);
		ay = pick(-200000, 200000);
		ox = pick(-span, span);
		oy = pick(-span, span);
		if (sel < 35) begin
			mx = pick(-2, 2);
			my = pick(-2, 2);
		end else if (sel < 70) begin
			mx = -ox + pick(-span / 2, span / 2);
			my = -oy + pick(-span / 2, span / 2);
		end else begin
			mx = pick(-2 * span, 2 * span);
			my = pick(-2 * span, 2 * span);
		end
		if (mx > 524287) mx = 524287;
		if (mx < -524288) mx = -524288;
		if (my > 524287) my = 524287;
		if (my < -524288) my = -524288;
		return make_query(ax + ox, ay + oy, mx, my, ax, ay, $urandom_range(1),
			$urandom_range(1), ra, rc);
	endfunction

	// Holds the word until the falling edge shows ready, so it moves at the
	// next rising edge, where the caller drives the following word or a gap.
	task automatic send_query(req_t q);
		@(posedge clk);
		req.valid <= 1'b1;
		req.circle_x <= q.circle_x;
		req.circle_y <= q.circle_y;
		req.move_x <= q.move_x;
		req.move_y <= q.move_y;
		req.arc_x <= q.arc_x;
		req.arc_y <= q.arc_y;
		req.quadrant_x_negative <= q.quadrant_x_negative;
		req.quadrant_y_negative <= q.quadrant_y_negative;
		req.arc_radius <= q.arc_radius;
		req.circle_radius <= q.circle_radius;
		do @(negedge clk); while (!req.ready);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(posedge clk);
			req.valid <= 1'b0;
		end
	endtask

	initial begin
		req_t directed[$];
		int burst;
		int sent;
		cycles = 0;
		stall_mode = 0;
		stall_left = 0;
		stall_phase = 0;
		rsp.ready = 1'b1;
		req.valid = 1'b0;
		{req.circle_x, req.circle_y, req.move_x, req.move_y, req.arc_x, req.arc_y} = '0;
		{req.quadrant_x_negative, req.quadrant_y_negative} = '0;
		{req.arc_radius, req.circle_radius} = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes.
		directed = {directed, make_query(-524288, -524288, -524288, -524288, -524288,
			-524288, 1, 1, 65535, 65535)};
		directed = {directed, make_query(524287, 524287, 524287, 524287, 524287, 524287,
			0, 0, 65535, 65535)};
		directed = {directed, make_query(524287, -524288, -524288, 524287, -524288, 524287,
			0, 1, 0, 0)};
		directed = {directed, make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		// Band, all four quadrants, with zero move.
		directed = {directed, make_query(1000, 1000, 0, 0, 0, 0, 0, 0, 1400, 100)};
		directed = {directed, make_query(-1000, 1000, 0, 0, 0, 0, 1, 0, 1400, 100)};
		directed = {directed, make_query(-1000, -1000, 0, 0, 0, 0, 1, 1, 1400, 100)};
		directed = {directed, make_query(1000, -1000, 0, 0, 0, 0, 0, 1, 1400, 100)};
		// Band but wrong quadrant.
		directed = {directed, make_query(1000, 1000, 0, 0, 0, 0, 1, 0, 1400, 100)};
		// Outside, approaching, receding, and too slow to count.
		directed = {directed, make_query(5000, 3000, -6000, -3000, 0, 0, 0, 0, 2000, 256)};
		directed = {directed, make_query(5000, 3000, 6000, 3000, 0, 0, 0, 0, 2000, 256)};
		directed = {directed, make_query(5000, 3000, -2, -1, 0, 0, 0, 0, 2000, 256)};
		// Outside, passing by with no real root.
		directed = {directed, make_query(5000, 5000, -100, 0, 0, 0, 0, 0, 1000, 10)};
		// Outside, reaching only after the step; and far away, saturating.
		directed = {directed, make_query(8000, 8000, -1000, -1000, 0, 0, 0, 0, 2000, 0)};
		directed = {directed, make_query(100000, 10, -3, 0, 0, 0, 0, 0, 100, 0)};
		// Inside, exit within the step and beyond it.
		directed = {directed, make_query(100, 100, 3000, 2000, 0, 0, 0, 0, 2000, 200)};
		directed = {directed, make_query(100, 100, 30, 20, 0, 0, 0, 0, 2000, 200)};
		directed = {directed, make_query(-100, -100, -3000, -2000, 0, 0, 1, 1, 2000, 200)};
		// Inside with no move.
		directed = {directed, make_query(100, 100, 0, 0, 0, 0, 0, 0, 2000, 200)};
		// Circle larger than the arc.
		directed = {directed, make_query(10, 10, 500, 500, 0, 0, 0, 0, 100, 3000)};
		directed = {directed, make_query(9000, 9000, -9000, -8000, 0, 0, 0, 0, 100, 3000)};
		// Moving along one axis by the smallest amount that counts.
		directed = {directed, make_query(100, 100, 3, 0, 0, 0, 0, 0, 2000, 0)};
		directed = {directed, make_query(3000, 10, -3, 0, 0, 0, 0, 0, 2000, 0)};

		foreach (directed[i])
			send_query(directed[i]);

		sent = 0;
		while (sent < RANDOM_QUERIES) begin
			burst = $urandom_range(30, 1);
			for (int i = 0; i < burst && sent < RANDOM_QUERIES; i++) begin
				send_query(random_query());
				sent++;
			end
			idle_cycles($urandom_range(2) == 0 ? 0 : $urandom_range(8, 1));
		end
		idle_cycles(1);

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("PASS swept_circle_vs_quarter_arc_time");
		else
			$display("FAIL swept_circle_vs_quarter_arc_time");
		$finish;
	end
endmodule
